// ----- design/sfm_pkg.sv -----
// Shared types and constants for the first-match substring search.
// No dependencies.
package sfm_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int RESULT_W   = 32;
	localparam int HALF_BYTES = CFG_DATA_W / BYTE_W;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [RESULT_W-1:0]   result_off_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEEDLE_LOW  = 2'd0,
		CFG_NEEDLE_HIGH = 2'd1,
		CFG_NEEDLE_LEN  = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

endpackage

// ----- design/sfm_match.sv -----
// Window compare for the substring search: checks the newest len window bytes
// against the needle, needle byte 0 against the oldest byte in range.
// Depends on sfm_pkg.
module sfm_match #(
	parameter int MAX_NEEDLE = 16
) (
	input  sfm_pkg::byte_t window [MAX_NEEDLE],
	input  sfm_pkg::byte_t needle [MAX_NEEDLE],
	input  sfm_pkg::len_t  len,
	input  logic           enough,
	output logic           match
);

	localparam int IDX_W = $clog2(MAX_NEEDLE);

	sfm_pkg::len_t pos;
	logic          hit;

	always_comb begin
		pos = '0;
		hit = enough && (len != '0) && (len <= sfm_pkg::LEN_W'(MAX_NEEDLE));
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			pos = len - sfm_pkg::LEN_W'(k) - sfm_pkg::LEN_W'(1);
			if (sfm_pkg::LEN_W'(k) < len && pos < sfm_pkg::LEN_W'(MAX_NEEDLE)) begin
				if (needle[k] != window[pos[IDX_W-1:0]])
					hit = 1'b0;
			end
		end
		match = hit;
	end

endmodule

// ----- design/substring_first_match.sv -----
// First-match substring search over a byte stream, top level.
// An accepted word passes the input register and window compare into the output register.
// Throughput: one word per cycle; the input register and the window compare
// behind it advance whenever the output register is free or being taken.
// Reset clears the needle registers, byte counter, report flag and valid bits.
// Depends on sfm_pkg and sfm_match.
module substring_first_match #(
	parameter int MAX_NEEDLE  = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  sfm_pkg::cfg_data_t           cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sfm_pkg::byte_t               haystack_byte,
	input  logic                         end_of_text,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output sfm_pkg::result_off_t         match_offset
);

	localparam int WIDE_W = OFFSET_BITS + sfm_pkg::RESULT_W;
	localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

	sfm_pkg::cfg_data_t needle_low_q;
	sfm_pkg::cfg_data_t needle_high_q;
	sfm_pkg::len_t      needle_len_q;

	logic               valid_s1;
	sfm_pkg::byte_t     byte_s1;
	logic               eot_s1;

	sfm_pkg::byte_t     win_q [MAX_NEEDLE];
	sfm_pkg::byte_t     win_next [MAX_NEEDLE];
	sfm_pkg::byte_t     needle [MAX_NEEDLE];
	logic [OFFSET_BITS-1:0] cnt_q;
	logic [OFFSET_BITS-1:0] cnt_next;
	logic               reported_q;

	logic               out_valid_q;
	logic               found_q;
	sfm_pkg::result_off_t offset_q;

	logic               adv_s1;
	logic               match;
	logic               emit;
	logic [WIDE_W-1:0]  off_wide;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_NEEDLE; gi++) begin : g_needle
			if (gi < sfm_pkg::HALF_BYTES) begin : g_low
				assign needle[gi] = needle_low_q[gi*sfm_pkg::BYTE_W +: sfm_pkg::BYTE_W];
			end else begin : g_high
				assign needle[gi] =
					needle_high_q[(gi-sfm_pkg::HALF_BYTES)*sfm_pkg::BYTE_W +: sfm_pkg::BYTE_W];
			end
			if (gi == 0) begin : g_head
				assign win_next[gi] = byte_s1;
			end else begin : g_tail
				assign win_next[gi] = win_q[gi-1];
			end
		end
	endgenerate

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			needle_len_q  <= '0;
		end else if (cfg_we) begin
			case (sfm_pkg::cfg_idx_t'(cfg_index))
				sfm_pkg::CFG_NEEDLE_LOW:  needle_low_q  <= cfg_data;
				sfm_pkg::CFG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				sfm_pkg::CFG_NEEDLE_LEN:  needle_len_q  <= cfg_data[sfm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign cnt_next = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + OFFSET_BITS'(1);

	sfm_match #(
		.MAX_NEEDLE (MAX_NEEDLE)
	) u_match (
		.window (win_next),
		.needle (needle),
		.len    (needle_len_q),
		.enough (cnt_next >= OFFSET_BITS'(needle_len_q)),
		.match  (match)
	);

	assign emit     = !reported_q && (match || eot_s1);
	assign off_wide = WIDE_W'(cnt_next) - WIDE_W'(needle_len_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= haystack_byte;
			eot_s1  <= end_of_text;
		end
	end

	// window shifts only while searching; stale bytes are never compared
	always_ff @(posedge clk) begin
		if (adv_s1 && !reported_q) begin
			for (int i = 0; i < MAX_NEEDLE; i++)
				win_q[i] <= win_next[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (adv_s1) begin
			if (eot_s1) begin
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				cnt_q      <= cnt_next;
				reported_q <= match;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			found_q  <= match;
			offset_q <= match ? off_wide[sfm_pkg::RESULT_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0)
		else $error("not-found result carries a nonzero offset");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && eot_s1 |=> cnt_q == '0 && !reported_q)
		else $error("stream state not cleared after last word");

	a_report_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reported_q) |-> out_valid_q && found_q)
		else $error("match recorded without a found result");

	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !eot_s1 |=> cnt_q >= $past(cnt_q))
		else $error("byte counter went backward mid-stream");

	a_no_result_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && reported_q |=> !out_valid_q || $past(out_valid_q && !out_ready))
		else $error("result emitted after the first match");

endmodule
